// ===== hw/rtl/tfcs_pkg.sv =====
// Shared types, constants and codes for the TTE frame clock sync block.
// No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps

package tfcs_pkg;

   localparam int TIME_W      = 64;
   localparam int WORD_W      = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;

   // transparent clock scaling: (tc * 10) >> 16, then * 536871 >> 26
   localparam int TC_SHIFT1 = 16;
   localparam int TC_SHIFT2 = 26;
   localparam int TCV_W     = TIME_W - TC_SHIFT1;
   localparam int TC_W      = TIME_W - TC_SHIFT2;
   localparam int RECIP_W   = 20;
   localparam logic [RECIP_W-1:0] TC_RECIP = 20'd536871;

   localparam int GAIN_SHIFT = 10;

   localparam logic [15:0] PCF_ETHERTYPE    = 16'h891D;
   localparam logic [7:0]  INTEGRATION_TYPE = 8'h02;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TX_DELAY   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPRESS_DELAY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_PRECISION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_LENGTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAFFIC_MARKER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_OFFSET   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CORR_MODE      = 3'd6;

   // result status codes
   localparam logic [1:0] STAT_REJECT = 2'd0;
   localparam logic [1:0] STAT_ACCEPT = 2'd1;
   localparam logic [1:0] STAT_TT     = 2'd2;
   localparam logic [1:0] STAT_OTHER  = 2'd3;

   // frame classes
   localparam logic [1:0] CLS_INTEG = 2'd0;
   localparam logic [1:0] CLS_TT    = 2'd1;
   localparam logic [1:0] CLS_OTHER = 2'd2;

   localparam logic MODE_DIRECT = 1'b0;
   localparam logic MODE_PI     = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] max_transmit_delay;
      logic [WORD_W-1:0] compression_delay;
      logic [WORD_W-1:0] sync_precision;
      logic [WORD_W-1:0] cycle_length;
      logic [WORD_W-1:0] traffic_marker;
      logic [WORD_W-1:0] schedule_offset;
      logic              correction_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        cls;
      logic [TIME_W-1:0] receive_time;
      logic [TCV_W-1:0]  tc_scaled;
      logic              cycle_zero;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== hw/rtl/tfcs_if.sv =====
// Channel interfaces: frame request, result, and register write port.
// Depends on tfcs_pkg for widths.
`timescale 1ns / 1ps

interface tfcs_req_if;
   logic                         valid;
   logic                         ready;
   logic [tfcs_pkg::TIME_W-1:0]  receive_time;
   logic [tfcs_pkg::WORD_W-1:0]  dest_prefix;
   logic [15:0]                  frame_ethertype;
   logic [7:0]                   control_type;
   logic [tfcs_pkg::TIME_W-1:0]  transparent_clock;
   logic [tfcs_pkg::WORD_W-1:0]  cycle_number;

   modport source (output valid, receive_time, dest_prefix, frame_ethertype,
                   control_type, transparent_clock, cycle_number,
                   input ready);
   modport sink   (input valid, receive_time, dest_prefix, frame_ethertype,
                   control_type, transparent_clock, cycle_number,
                   output ready);
endinterface

interface tfcs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         frame_status;
   logic                               arm_timer;
   logic [tfcs_pkg::TIME_W-1:0]        timer_deadline;
   logic signed [tfcs_pkg::TIME_W-1:0] clock_error;
   logic [tfcs_pkg::TIME_W-1:0]        local_time_out;

   modport source (output valid, frame_status, arm_timer, timer_deadline,
                   clock_error, local_time_out, input ready);
   modport sink   (input valid, frame_status, arm_timer, timer_deadline,
                   clock_error, local_time_out, output ready);
endinterface

interface tfcs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tfcs_pkg::CSR_IDX_W-1:0] index;
   logic [tfcs_pkg::WORD_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tfcs_front.sv =====
// Front end: accepts frames, classifies them and pre-scales the
// transparent clock. Depends on tfcs_pkg and tfcs_req_if.
`timescale 1ns / 1ps

module tfcs_front (
   tfcs_req_if.sink              req_ch,
   input  tfcs_pkg::cfg_type     cfg,
   input  tfcs_pkg::qstat_type   qstat,
   output logic                  push,
   output tfcs_pkg::qentry_type  push_entry
);

   logic [tfcs_pkg::TIME_W-1:0] tc_times10;

   assign req_ch.ready = !qstat.full;
   assign push         = req_ch.valid && !qstat.full;

   // x*10 mod 2^64 as x*8 + x*2
   assign tc_times10 = (req_ch.transparent_clock << 3) + (req_ch.transparent_clock << 1);

   always_comb begin
      push_entry.receive_time = req_ch.receive_time;
      push_entry.tc_scaled    = tc_times10[tfcs_pkg::TIME_W-1:tfcs_pkg::TC_SHIFT1];
      push_entry.cycle_zero   = (req_ch.cycle_number == '0);
      if (req_ch.frame_ethertype == tfcs_pkg::PCF_ETHERTYPE) begin
         if (req_ch.control_type == tfcs_pkg::INTEGRATION_TYPE) begin
            push_entry.cls = tfcs_pkg::CLS_INTEG;
         end else begin
            push_entry.cls = tfcs_pkg::CLS_OTHER;
         end
      end else if (req_ch.dest_prefix == cfg.traffic_marker) begin
         push_entry.cls = tfcs_pkg::CLS_TT;
      end else begin
         push_entry.cls = tfcs_pkg::CLS_OTHER;
      end
   end

endmodule

// ===== hw/rtl/tfcs_queue.sv =====
// Short FIFO of classified frames between front and back end.
// Depends on tfcs_pkg.
`timescale 1ns / 1ps

module tfcs_queue #(
   parameter int DEPTH = tfcs_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tfcs_pkg::qentry_type  push_entry,
   input  logic                  pop,
   output tfcs_pkg::qentry_type  head,
   output tfcs_pkg::qstat_type   qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   tfcs_pkg::qentry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/tfcs_back.sv =====
// Back end: sequencer that runs the clock correction for integration
// frames and holds the result register. Depends on tfcs_pkg, tfcs_rsp_if.
`timescale 1ns / 1ps

module tfcs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tfcs_pkg::cfg_type     cfg,
   input  tfcs_pkg::qstat_type   qstat,
   input  tfcs_pkg::qentry_type  head,
   output logic                  pop,
   tfcs_rsp_if.source            rsp_ch
);

   localparam int TW   = tfcs_pkg::TIME_W;
   localparam int WW   = tfcs_pkg::WORD_W;
   localparam int HALF = tfcs_pkg::TCV_W / 2;
   localparam int PP_W = HALF + tfcs_pkg::RECIP_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_TC    = 4'd2;
   localparam logic [3:0] ST_PERM  = 4'd3;
   localparam logic [3:0] ST_SEED  = 4'd4;
   localparam logic [3:0] ST_ERR   = 4'd5;
   localparam logic [3:0] ST_CHECK = 4'd6;
   localparam logic [3:0] ST_GAIN  = 4'd7;
   localparam logic [3:0] ST_PI    = 4'd8;
   localparam logic [3:0] ST_ARM   = 4'd9;
   localparam logic [3:0] ST_EMIT  = 4'd10;

   function automatic logic [TW-1:0] mul_p_gain(input logic [TW-1:0] x);
      mul_p_gain = (x << 8) + (x << 5) + (x << 3) + (x << 2);   // * 300
   endfunction

   function automatic logic [TW-1:0] mul_i_gain(input logic [TW-1:0] x);
      mul_i_gain = (x << 9) + (x << 7) + (x << 5) + (x << 4) + (x << 3) + (x << 2);
   endfunction                                                   // * 700

   function automatic logic [TW-1:0] asr_gain(input logic [TW-1:0] x);
      asr_gain = TW'($signed(x) >>> tfcs_pkg::GAIN_SHIFT);
   endfunction

   logic [3:0]              state_ff, state_in;
   logic [TW-1:0]           lt_ff, lt_in;
   logic [TW-1:0]           integ_ff, integ_in;
   tfcs_pkg::qentry_type    ent_ff, ent_in;
   logic [PP_W-1:0]         pp0_ff, pp0_in, pp1_ff, pp1_in;
   logic [tfcs_pkg::TC_W-1:0] tc_ff, tc_in;
   logic [TW-1:0]           perm_ff, perm_in;
   logic [TW-1:0]           err_ff, err_in;
   logic [TW-1:0]           pprod_ff, pprod_in, iprod_ff, iprod_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic                    res_arm_ff, res_arm_in;
   logic [TW-1:0]           res_dl_ff, res_dl_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff;
   logic                    rsp_arm_ff;
   logic [TW-1:0]           rsp_dl_ff, rsp_err_ff, rsp_lt_ff;
   logic                    load_rsp;

   logic                    out_free;
   logic [TW-1:0]           delays;
   logic [TW-1:0]           tc_sum;
   logic [TW-1:0]           win_sum;
   logic [WW:0]             win_width;
   logic                    in_window;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // 2 * max_transmit_delay + compression_delay at full width
   assign delays = TW'({cfg.max_transmit_delay, 1'b0}) + TW'(cfg.compression_delay);

   assign tc_sum = TW'(pp0_ff) + (TW'(pp1_ff) << HALF);

   // |err| < precision on the modular difference
   assign win_sum   = err_ff + TW'(cfg.sync_precision - WW'(1));
   assign win_width = {cfg.sync_precision, 1'b0} - (WW + 1)'(1);
   assign in_window = (cfg.sync_precision != '0) && (win_sum < TW'(win_width));

   always_comb begin
      state_in      = state_ff;
      lt_in         = lt_ff;
      integ_in      = integ_ff;
      ent_in        = ent_ff;
      pp0_in        = pp0_ff;
      pp1_in        = pp1_ff;
      tc_in         = tc_ff;
      perm_in       = perm_ff;
      err_in        = err_ff;
      pprod_in      = pprod_ff;
      iprod_in      = iprod_ff;
      res_status_in = res_status_ff;
      res_arm_in    = res_arm_ff;
      res_dl_in     = res_dl_ff;
      pop           = 1'b0;
      load_rsp      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop        = 1'b1;
               ent_in     = head;
               res_arm_in = 1'b0;
               res_dl_in  = '0;
               err_in     = '0;
               case (head.cls)
                  tfcs_pkg::CLS_INTEG: begin
                     state_in = ST_MUL;
                  end
                  tfcs_pkg::CLS_TT: begin
                     res_status_in = tfcs_pkg::STAT_TT;
                     state_in      = ST_EMIT;
                  end
                  default: begin
                     res_status_in = tfcs_pkg::STAT_OTHER;
                     state_in      = ST_EMIT;
                  end
               endcase
            end
         end
         ST_MUL: begin
            // 48 x 20 product split into two 24 x 20 halves
            pp0_in   = PP_W'(ent_ff.tc_scaled[HALF-1:0] * tfcs_pkg::TC_RECIP);
            pp1_in   = PP_W'(ent_ff.tc_scaled[tfcs_pkg::TCV_W-1:HALF] * tfcs_pkg::TC_RECIP);
            state_in = ST_TC;
         end
         ST_TC: begin
            tc_in    = tc_sum[TW-1:tfcs_pkg::TC_SHIFT2];
            state_in = ST_PERM;
         end
         ST_PERM: begin
            perm_in  = ent_ff.receive_time + TW'(cfg.max_transmit_delay) - TW'(tc_ff);
            state_in = ST_SEED;
         end
         ST_SEED: begin
            if (lt_ff == '0) begin
               lt_in = perm_ff - delays;
            end
            state_in = ST_ERR;
         end
         ST_ERR: begin
            err_in   = perm_ff - lt_ff - delays;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!in_window) begin
               res_status_in = tfcs_pkg::STAT_REJECT;
               if (cfg.correction_mode == tfcs_pkg::MODE_DIRECT) begin
                  lt_in = '0;
               end
               state_in = ST_EMIT;
            end else if (cfg.correction_mode == tfcs_pkg::MODE_PI) begin
               integ_in = integ_ff + err_ff;
               state_in = ST_GAIN;
            end else begin
               lt_in    = lt_ff + err_ff;
               state_in = ST_ARM;
            end
         end
         ST_GAIN: begin
            pprod_in = mul_p_gain(err_ff);
            iprod_in = mul_i_gain(integ_ff);
            state_in = ST_PI;
         end
         ST_PI: begin
            lt_in    = lt_ff + asr_gain(pprod_ff) + asr_gain(iprod_ff);
            state_in = ST_ARM;
         end
         ST_ARM: begin
            res_status_in = tfcs_pkg::STAT_ACCEPT;
            res_arm_in    = ent_ff.cycle_zero;
            res_dl_in     = ent_ff.cycle_zero ? lt_ff + TW'(cfg.schedule_offset) : '0;
            lt_in         = lt_ff + TW'(cfg.cycle_length);
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lt_ff        <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lt_ff        <= lt_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff        <= ent_in;
      pp0_ff        <= pp0_in;
      pp1_ff        <= pp1_in;
      tc_ff         <= tc_in;
      perm_ff       <= perm_in;
      err_ff        <= err_in;
      pprod_ff      <= pprod_in;
      iprod_ff      <= iprod_in;
      res_status_ff <= res_status_in;
      res_arm_ff    <= res_arm_in;
      res_dl_ff     <= res_dl_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_arm_ff    <= res_arm_ff;
         rsp_dl_ff     <= res_dl_ff;
         rsp_err_ff    <= err_ff;
         rsp_lt_ff     <= lt_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.frame_status   = rsp_status_ff;
   assign rsp_ch.arm_timer      = rsp_arm_ff;
   assign rsp_ch.timer_deadline = rsp_dl_ff;
   assign rsp_ch.clock_error    = $signed(rsp_err_ff);
   assign rsp_ch.local_time_out = rsp_lt_ff;

   a_arm_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_arm_ff |-> rsp_status_ff == tfcs_pkg::STAT_ACCEPT)
      else $error("timer armed on a frame that was not accepted");

   a_non_integ_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == tfcs_pkg::STAT_TT ||
                       rsp_status_ff == tfcs_pkg::STAT_OTHER)
      |-> rsp_err_ff == '0 && rsp_dl_ff == '0 && !rsp_arm_ff)
      else $error("non-integration result carries correction data");

   a_start_needs_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && !pop |=> state_ff == ST_IDLE)
      else $error("sequencer left idle without taking a queued item");

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && !out_free |=> state_ff == ST_EMIT && rsp_valid_ff)
      else $error("result dropped while output register was held");

endmodule

// ===== hw/rtl/tte_frame_clock_sync_core.sv =====
// Top level of the TTE frame clock sync block: register file, front end,
// queue and back end. Depends on tfcs_pkg, tfcs_if and the tfcs_* modules.
// Path from accept to result valid: queue entry, then back-end states
// IDLE, EMIT (non-integration) or IDLE, MUL, TC, PERM, SEED, ERR, CHECK,
// then EMIT (rejected), ARM, EMIT (direct) or GAIN, PI, ARM, EMIT (PI).
// Back-end sequencer takes one item at a time; queue absorbs bursts.
// Reset (synchronous, active high) zeroes local time, integral, registers.
`timescale 1ns / 1ps

module tte_frame_clock_sync_core #(
   parameter int QUEUE_DEPTH = tfcs_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   tfcs_req_if.sink    req_ch,
   tfcs_rsp_if.source  rsp_ch,
   tfcs_csr_if.sink    csr_ch
);

   // Configuration registers. Writes must come only while idle; the block
   // does not enforce this. Front and back ends read them without shadowing.
   tfcs_pkg::cfg_type cfg_ff, cfg_in;

   // front -> queue -> back
   logic                 push;
   logic                 pop;
   tfcs_pkg::qentry_type push_entry;
   tfcs_pkg::qentry_type head;
   tfcs_pkg::qstat_type  qstat;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            tfcs_pkg::CSR_MAX_TX_DELAY:   cfg_in.max_transmit_delay = csr_ch.data;
            tfcs_pkg::CSR_COMPRESS_DELAY: cfg_in.compression_delay  = csr_ch.data;
            tfcs_pkg::CSR_SYNC_PRECISION: cfg_in.sync_precision     = csr_ch.data;
            tfcs_pkg::CSR_CYCLE_LENGTH:   cfg_in.cycle_length       = csr_ch.data;
            tfcs_pkg::CSR_TRAFFIC_MARKER: cfg_in.traffic_marker     = csr_ch.data;
            tfcs_pkg::CSR_SCHED_OFFSET:   cfg_in.schedule_offset    = csr_ch.data;
            tfcs_pkg::CSR_CORR_MODE:      cfg_in.correction_mode    = csr_ch.data[0];
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify and pre-scale the transparent clock in the
   // accept cycle, push into the queue.
   tfcs_front u_front (
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   tfcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   // Back end: one item at a time through the correction sequence,
   // result parked in the output register until taken.
   tfcs_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .qstat  (qstat),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== dv/tte_frame_clock_sync_core_test.sv =====
// Self-checking bench for tte_frame_clock_sync_core: directed and random frames,
// with every result scored against a frame-level clock sync predictor.
// Depends on tfcs_pkg, the tfcs_*_if interfaces and the core RTL.
`timescale 1ns / 1ps

module tte_frame_clock_sync_core_test;

   localparam int TIME_W    = tfcs_pkg::TIME_W;
   localparam int WORD_W    = tfcs_pkg::WORD_W;
   localparam int CSR_IDX_W = tfcs_pkg::CSR_IDX_W;

   // transparent clock scaling and PI gains (gain shift comes from the package)
   localparam logic [TIME_W-1:0] TC_MUL = 10;
   localparam logic [TIME_W-1:0] P_GAIN = 300;
   localparam logic [TIME_W-1:0] I_GAIN = 700;
   // longest idle burst on either side
   localparam int GAP_MAX = 13;

   typedef struct packed {
      logic [TIME_W-1:0] receive_time;
      logic [WORD_W-1:0] dest_prefix;
      logic [15:0]       frame_ethertype;
      logic [7:0]        control_type;
      logic [TIME_W-1:0] transparent_clock;
      logic [WORD_W-1:0] cycle_number;
   } frame_item_type;

   typedef struct packed {
      logic [1:0]        frame_status;
      logic              arm_timer;
      logic [TIME_W-1:0] timer_deadline;
      logic [TIME_W-1:0] clock_error;
      logic [TIME_W-1:0] local_time_out;
   } sync_result_type;

   // Tracks the synchronized time and integral, predicts one result per
   // accepted frame and scores results in order.
   class sync_tracker_type;
      tfcs_pkg::cfg_type regs;
      logic [TIME_W-1:0] local_time;
      logic [TIME_W-1:0] integral;
      sync_result_type   pending_results[$];
      int                mismatches;

      function new();
         regs       = '0;
         local_time = '0;
         integral   = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            tfcs_pkg::CSR_MAX_TX_DELAY:   regs.max_transmit_delay = data;
            tfcs_pkg::CSR_COMPRESS_DELAY: regs.compression_delay  = data;
            tfcs_pkg::CSR_SYNC_PRECISION: regs.sync_precision     = data;
            tfcs_pkg::CSR_CYCLE_LENGTH:   regs.cycle_length       = data;
            tfcs_pkg::CSR_TRAFFIC_MARKER: regs.traffic_marker     = data;
            tfcs_pkg::CSR_SCHED_OFFSET:   regs.schedule_offset    = data;
            tfcs_pkg::CSR_CORR_MODE:      regs.correction_mode    = data[0];
            default: ;
         endcase
      endfunction

      // 2 * max delay + compression delay, no 32-bit wrap
      function logic [TIME_W-1:0] total_delay();
         return 2 * {32'b0, regs.max_transmit_delay} + {32'b0, regs.compression_delay};
      endfunction

      function logic [TIME_W-1:0] tc_cycles(logic [TIME_W-1:0] tclk);
         logic [TIME_W-1:0] v;
         v = (tclk * TC_MUL) >> tfcs_pkg::TC_SHIFT1;
         v = (v * TIME_W'(tfcs_pkg::TC_RECIP)) >> tfcs_pkg::TC_SHIFT2;
         return v;
      endfunction

      // wrapped product, then arithmetic shift
      function logic [TIME_W-1:0] gain_term(logic [TIME_W-1:0] gain, logic [TIME_W-1:0] x);
         logic signed [TIME_W-1:0] p;
         p = gain * x;
         return p >>> tfcs_pkg::GAIN_SHIFT;
      endfunction

      // receive time that lands err on the given offset from current state
      function logic [TIME_W-1:0] aimed_receive_time(logic [TIME_W-1:0] tclk,
                                                     logic [TIME_W-1:0] offset);
         return local_time + total_delay() + offset
                - {32'b0, regs.max_transmit_delay} + tc_cycles(tclk);
      endfunction

      function sync_result_type predict_frame(frame_item_type f);
         sync_result_type   r;
         logic [TIME_W-1:0] delays;
         logic [TIME_W-1:0] perm;
         logic [TIME_W-1:0] sched;
         logic [TIME_W-1:0] err;
         logic [TIME_W-1:0] prec;
         logic              ok;
         r = '0;
         r.frame_status = tfcs_pkg::STAT_OTHER;
         if (f.frame_ethertype == tfcs_pkg::PCF_ETHERTYPE) begin
            if (f.control_type == tfcs_pkg::INTEGRATION_TYPE) begin
               delays = total_delay();
               prec   = {32'b0, regs.sync_precision};
               perm   = f.receive_time
                        + ({32'b0, regs.max_transmit_delay} - tc_cycles(f.transparent_clock));
               if (local_time == '0) begin
                  local_time = perm - delays;
               end
               sched = local_time + delays;
               err   = perm - sched;
               ok    = (prec != '0) && (err + prec - 1 < 2 * prec - 1);
               if (ok) begin
                  if (regs.correction_mode == tfcs_pkg::MODE_PI) begin
                     integral   = integral + err;
                     local_time = local_time + gain_term(P_GAIN, err)
                                  + gain_term(I_GAIN, integral);
                  end else begin
                     local_time = local_time + err;
                  end
                  if (f.cycle_number == '0) begin
                     r.arm_timer      = 1'b1;
                     r.timer_deadline = local_time + {32'b0, regs.schedule_offset};
                  end
                  local_time     = local_time + {32'b0, regs.cycle_length};
                  r.frame_status = tfcs_pkg::STAT_ACCEPT;
               end else begin
                  if (regs.correction_mode == tfcs_pkg::MODE_DIRECT) begin
                     local_time = '0;
                  end
                  r.frame_status = tfcs_pkg::STAT_REJECT;
               end
               r.clock_error = err;
            end
         end else if (f.dest_prefix == regs.traffic_marker) begin
            r.frame_status = tfcs_pkg::STAT_TT;
         end
         r.local_time_out = local_time;
         return r;
      endfunction

      function void note_frame(frame_item_type f);
         pending_results.push_back(predict_frame(f));
      endfunction

      function void compare_field(string name, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            mismatches++;
         end
      endfunction

      function void check_result(sync_result_type seen);
         sync_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("frame_status", TIME_W'(want.frame_status),
                       TIME_W'(seen.frame_status));
         compare_field("arm_timer", TIME_W'(want.arm_timer), TIME_W'(seen.arm_timer));
         compare_field("timer_deadline", want.timer_deadline, seen.timer_deadline);
         compare_field("clock_error", want.clock_error, seen.clock_error);
         compare_field("local_time_out", want.local_time_out, seen.local_time_out);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   tfcs_req_if req_ch();
   tfcs_rsp_if rsp_ch();
   tfcs_csr_if csr_ch();

   sync_tracker_type tracker = new();

   // idle knobs, changed per phase; both zero in the last phase
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int stall_left    = 0;

   tte_frame_clock_sync_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: score each accepted item, then pick next cycle's ready.
   // Stall bursts are bounded by GAP_MAX.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_result({rsp_ch.frame_status, rsp_ch.arm_timer, rsp_ch.timer_deadline,
                               rsp_ch.clock_error, rsp_ch.local_time_out});
      end
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, GAP_MAX - 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Writes all seven registers back to back; valid stays high throughout.
   task automatic program_regs(tfcs_pkg::cfg_type c);
      logic [CSR_IDX_W-1:0] idx [7];
      logic [WORD_W-1:0]    val [7];
      idx = '{tfcs_pkg::CSR_MAX_TX_DELAY, tfcs_pkg::CSR_COMPRESS_DELAY,
              tfcs_pkg::CSR_SYNC_PRECISION, tfcs_pkg::CSR_CYCLE_LENGTH,
              tfcs_pkg::CSR_TRAFFIC_MARKER, tfcs_pkg::CSR_SCHED_OFFSET,
              tfcs_pkg::CSR_CORR_MODE};
      val = '{c.max_transmit_delay, c.compression_delay, c.sync_precision, c.cycle_length,
              c.traffic_marker, c.schedule_offset, WORD_W'(c.correction_mode)};
      foreach (idx[i]) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[i];
         csr_ch.data  <= val[i];
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         tracker.set_reg(idx[i], val[i]);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Drives one item and holds it until taken. The prediction is made here,
   // right at acceptance, so the next generated item sees up-to-date state.
   task automatic send_frame(frame_item_type f);
      req_ch.valid             <= 1'b1;
      req_ch.receive_time      <= f.receive_time;
      req_ch.dest_prefix       <= f.dest_prefix;
      req_ch.frame_ethertype   <= f.frame_ethertype;
      req_ch.control_type      <= f.control_type;
      req_ch.transparent_clock <= f.transparent_clock;
      req_ch.cycle_number      <= f.cycle_number;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_frame(f);
      if ($urandom_range(0, 99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, GAP_MAX)) @(posedge clock);
      end
   endtask

   // Block is idle once all results are back; a few spare cycles on top.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   function automatic frame_item_type sync_frame(logic [TIME_W-1:0] rx,
                                                 logic [TIME_W-1:0] tclk,
                                                 logic [WORD_W-1:0] cyc);
      frame_item_type f;
      f.receive_time      = rx;
      f.dest_prefix       = $urandom;
      f.frame_ethertype   = tfcs_pkg::PCF_ETHERTYPE;
      f.control_type      = tfcs_pkg::INTEGRATION_TYPE;
      f.transparent_clock = tclk;
      f.cycle_number      = cyc;
      return f;
   endfunction

   // integration frame whose clock error comes out at the given offset
   function automatic frame_item_type aimed_frame(logic [TIME_W-1:0] offset,
                                                  logic [WORD_W-1:0] cyc);
      logic [TIME_W-1:0] tclk;
      tclk = {$urandom, $urandom};
      return sync_frame(tracker.aimed_receive_time(tclk, offset), tclk, cyc);
   endfunction

   function automatic frame_item_type plain_frame(logic [WORD_W-1:0] prefix,
                                                  logic [15:0] etype,
                                                  logic [7:0] ctype);
      frame_item_type f;
      f.receive_time      = {$urandom, $urandom};
      f.dest_prefix       = prefix;
      f.frame_ethertype   = etype;
      f.control_type      = ctype;
      f.transparent_clock = {$urandom, $urandom};
      f.cycle_number      = $urandom;
      return f;
   endfunction

   // Mostly inside the window, some right on its edges, a few well outside.
   function automatic logic [TIME_W-1:0] pick_offset();
      logic [WORD_W-1:0] prec;
      logic [TIME_W-1:0] mag;
      int unsigned       pick;
      prec = tracker.regs.sync_precision;
      pick = $urandom_range(0, 99);
      if (prec == '0) begin
         mag = TIME_W'($urandom_range(0, 1000));
      end else if (pick < 70) begin
         mag = TIME_W'($urandom_range(0, prec - 1));
      end else if (pick < 85) begin
         mag = TIME_W'(prec - $urandom_range(0, 1));
      end else if (pick < 95) begin
         mag = TIME_W'(prec + $urandom_range(0, 1000));
      end else begin
         return {$urandom, $urandom};
      end
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic frame_item_type random_frame();
      int unsigned       pick;
      logic [WORD_W-1:0] cyc;
      logic [7:0]        ctype;
      pick  = $urandom_range(0, 99);
      cyc   = ($urandom_range(0, 2) == 0) ? '0 : WORD_W'($urandom);
      ctype = 8'($urandom);
      if (ctype == tfcs_pkg::INTEGRATION_TYPE) begin
         ctype = 8'hFF;
      end
      if (pick < 60) return aimed_frame(pick_offset(), cyc);
      if (pick < 70) return sync_frame({$urandom, $urandom}, {$urandom, $urandom}, cyc);
      if (pick < 82) return plain_frame(tracker.regs.traffic_marker, 16'($urandom), ctype);
      if (pick < 91) return plain_frame($urandom, tfcs_pkg::PCF_ETHERTYPE, ctype);
      return plain_frame($urandom, 16'($urandom), 8'($urandom));
   endfunction

   // Register settings per random phase: moderate ones by default, mode
   // alternating; full-range random, all ones and a zeroed set as extremes.
   function automatic tfcs_pkg::cfg_type phase_regs(int phase);
      tfcs_pkg::cfg_type c;
      c.max_transmit_delay = $urandom_range(0, 100000);
      c.compression_delay  = $urandom_range(0, 100000);
      c.sync_precision     = $urandom_range(1, 5000);
      c.cycle_length       = $urandom_range(0, 1 << 20);
      c.traffic_marker     = $urandom;
      c.schedule_offset    = $urandom;
      c.correction_mode    = phase[0] ? tfcs_pkg::MODE_PI : tfcs_pkg::MODE_DIRECT;
      case (phase)
         2: begin
            c.max_transmit_delay = $urandom;
            c.compression_delay  = $urandom;
            c.sync_precision     = $urandom;
            c.cycle_length       = $urandom;
            c.correction_mode    = 1'($urandom_range(0, 1));
         end
         3: begin
            c = '1;
         end
         4: begin
            // zero precision: nothing integrates
            c.max_transmit_delay = '0;
            c.compression_delay  = '0;
            c.sync_precision     = '0;
            c.cycle_length       = '0;
            c.schedule_offset    = '0;
         end
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      tfcs_pkg::cfg_type c;
      int                phase;

      reset                    <= 1'b1;
      req_ch.valid             <= 1'b0;
      req_ch.receive_time      <= '0;
      req_ch.dest_prefix       <= '0;
      req_ch.frame_ethertype   <= '0;
      req_ch.control_type      <= '0;
      req_ch.transparent_clock <= '0;
      req_ch.cycle_number      <= '0;
      csr_ch.valid             <= 1'b0;
      csr_ch.index             <= '0;
      csr_ch.data              <= '0;
      req_gap_pct              = 20;
      rsp_stall_pct            = 10;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset values: zero precision rejects the integration
      // frame, and a zero prefix matches the zero marker.
      send_frame(sync_frame({$urandom, $urandom}, '0, '0));
      send_frame(plain_frame('0, 16'h0800, 8'h00));
      send_frame(plain_frame($urandom, tfcs_pkg::PCF_ETHERTYPE, 8'hFF));
      settle();

      // Direct correction, window of +-399.
      c = {32'd1500, 32'd700, 32'd400, 32'd50000, 32'hA5C3_0F01, 32'd2000,
           tfcs_pkg::MODE_DIRECT};
      program_regs(c);
      send_frame(aimed_frame('0, '0));            // seeds local time, arms timer
      send_frame(aimed_frame(64'd399, '1));       // top edge of window
      send_frame(aimed_frame(-64'd399, '0));      // bottom edge of window
      send_frame(aimed_frame('0, 32'd7));
      send_frame(aimed_frame(64'd400, '0));       // miss: local time cleared
      // Reseed with the permanence point 5 below wrap, then correct
      // across the wrap.
      send_frame(sync_frame(64'hFFFF_FFFF_FFFF_FA1F, '0, '0));
      send_frame(aimed_frame(-64'd399, '0));
      send_frame(aimed_frame(-64'd400, '1));      // miss just below the window
      send_frame(plain_frame(c.traffic_marker, 16'h88F7, 8'h02));
      send_frame(plain_frame(c.traffic_marker ^ 32'h1, 16'h0800, 8'h00));
      send_frame('1);
      send_frame('0);
      send_frame(plain_frame($urandom, tfcs_pkg::PCF_ETHERTYPE, 8'h00));
      settle();

      // Every register at its maximum, PI mode, widest window.
      c = '1;
      program_regs(c);
      send_frame(aimed_frame('0, '0));
      send_frame(aimed_frame(64'hFFFF_FFFE, '0));
      send_frame(aimed_frame(-64'hFFFF_FFFE, '1));
      send_frame(aimed_frame(64'hFFFF_FFFF, '0)); // PI miss leaves state alone
      send_frame(plain_frame('1, 16'h0800, 8'h00));
      send_frame(sync_frame('1, '1, '0));
      settle();

      // Random phases; the last one runs with no idling on either side.
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 5) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = $urandom_range(0, 2) * 15;
            rsp_stall_pct = $urandom_range(0, 2) * 10;
         end
         program_regs(phase_regs(phase));
         repeat (105) send_frame(random_frame());
         settle();
      end

      if (tracker.mismatches == 0) begin
         $display("tte_frame_clock_sync_core_test: done, clean");
      end else begin
         $display("tte_frame_clock_sync_core_test: done, errors");
      end
      $finish;
   end

   // Hang guard: several times the slowest clean run.
   initial begin
      #5_000_000;
      $display("tte_frame_clock_sync_core_test: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tfcs_pkg.sv
hw/rtl/tfcs_if.sv
hw/rtl/tfcs_front.sv
hw/rtl/tfcs_queue.sv
hw/rtl/tfcs_back.sv
hw/rtl/tte_frame_clock_sync_core.sv
dv/tte_frame_clock_sync_core_test.sv
